// ===== sv/lion_pkg.sv =====
package lion_pkg;

  // Register index codes of the configuration port
  typedef enum logic [1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_INTERP_BETA   = 2'd1,
    REG_MOMENTUM_BETA = 2'd2,
    REG_WEIGHT_DECAY  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [31:0] RST_LEARNING_RATE = 32'h38D1_B717;
  localparam logic [31:0] RST_INTERP_BETA   = 32'h3F66_6666;
  localparam logic [31:0] RST_MOMENTUM_BETA = 32'h3F7D_70A4;
  localparam logic [31:0] RST_WEIGHT_DECAY  = 32'h0000_0000;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
  localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] param_in;
    logic [31:0] grad_in;
    logic [31:0] momentum_in;
    logic        last_element;
  } in_word_t;

  typedef struct packed {
    logic [31:0] param_out;
    logic [31:0] momentum_out;
    logic        last_out;
  } out_word_t;

  // Round to nearest even and pack; value is m * 2^e, m nonzero
  function automatic logic [31:0] rnd_pack(logic sgn, logic signed [12:0] e,
                                           logic [47:0] m);
    int                 lz;
    logic [47:0]        mn;
    logic [47:0]        sh;
    logic signed [12:0] be;
    logic [5:0]         shamt;
    logic               st;
    logic               up;
    logic [24:0]        m25;
    logic [23:0]        mant;
    logic [7:0]         ef;
    lz = 0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 47 - i;
    end
    mn = m << lz;
    be = e + 13'sd174 - 13'(lz);
    if (be < 13'sd1) begin
      shamt = (be < -13'sd61) ? 6'd63 : 6'(13'sd1 - be);
    end else begin
      shamt = 6'd0;
    end
    sh = mn >> shamt;
    st = |(mn & ~({48{1'b1}} << shamt));
    if (shamt != 6'd0) be = 13'sd1;
    up = sh[23] & (st | (|sh[22:0]) | sh[24]);
    m25 = {1'b0, sh[47:24]} + {24'd0, up};
    if (m25[24]) begin
      mant = m25[24:1];
      be = be + 13'sd1;
    end else begin
      mant = m25[23:0];
    end
    if (be >= 13'sd255) return {sgn, 8'hFF, 23'd0};
    ef = mant[23] ? be[7:0] : 8'd0;
    return {sgn, ef, mant[22:0]};
  endfunction

  // Single precision multiply
  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic               s;
    logic               nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic signed [12:0] e;
    s     = a[31] ^ b[31];
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zer_a = (a[30:0] == 31'd0);
    zer_b = (b[30:0] == 31'd0);
    if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) return FP_QNAN;
    if (inf_a || inf_b) return {s, 8'hFF, 23'd0};
    if (zer_a || zer_b) return {s, 31'd0};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    e  = $signed({5'd0, ea}) + $signed({5'd0, eb}) - 13'sd300;
    return rnd_pack(s, e, {24'd0, ma} * {24'd0, mb});
  endfunction

  // Single precision add
  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic               nan_a, nan_b, inf_a, inf_b;
    logic [31:0]        x, y;
    logic [7:0]         ex, ey, d;
    logic [26:0]        ax, by, bs;
    logic               stb;
    logic [27:0]        sum;
    logic signed [12:0] e;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (nan_a || nan_b) return FP_QNAN;
    if (inf_a && inf_b && (a[31] != b[31])) return FP_QNAN;
    if (inf_a) return a;
    if (inf_b) return b;
    // larger magnitude first
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d   = ex - ey;
    ax  = {x[30:23] != 8'd0, x[22:0], 3'b000};
    by  = {y[30:23] != 8'd0, y[22:0], 3'b000};
    bs  = by >> d;
    stb = |(by & ~({27{1'b1}} << d));
    bs[0] = bs[0] | stb;
    if (x[31] == y[31]) begin
      sum = {1'b0, ax} + {1'b0, bs};
    end else begin
      sum = {1'b0, ax} - {1'b0, bs};
    end
    if (sum == 28'd0) return {x[31] & y[31], 31'd0};
    e = $signed({5'd0, ex}) - 13'sd173;
    return rnd_pack(x[31], e, {sum, 20'd0});
  endfunction

  function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

endpackage

// ===== sv/lion_optimizer_update.sv =====
// Lion optimizer step on IEEE single precision words, one element per word.
// Each input word gives parameter, gradient and momentum; the output word
// gives the updated parameter and momentum (round to nearest even, subnormals
// supported, every NaN sent as 0x7FC00000) and passes the last flag along.
// The datapath is a five stage pipeline (input register, products, sums,
// decay/step products, final subtract into the output register): a word is
// taken every cycle while in_stall_o is low and passes through the stages in
// order. A stall holds the whole pipe; empty stages still fill. Values derived
// from the registers (1-beta, lr*wd, 1-lr*wd) are registered, 1-lr*wd from lr*wd.
module lion_optimizer_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lion_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lion_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [lion_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);

  logic [31:0] lr_q, b1_q, b2_q, wd_q;
  logic [31:0] omb1_q, omb2_q, lrwd_q, decay_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= lion_pkg::RST_LEARNING_RATE;
      b1_q <= lion_pkg::RST_INTERP_BETA;
      b2_q <= lion_pkg::RST_MOMENTUM_BETA;
      wd_q <= lion_pkg::RST_WEIGHT_DECAY;
    end else if (cfg_we_i) begin
      unique case (lion_pkg::cfg_reg_e'(cfg_idx_i))
        lion_pkg::REG_LEARNING_RATE: lr_q <= cfg_data_i;
        lion_pkg::REG_INTERP_BETA:   b1_q <= cfg_data_i;
        lion_pkg::REG_MOMENTUM_BETA: b2_q <= cfg_data_i;
        lion_pkg::REG_WEIGHT_DECAY:  wd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived constants, recomputed every cycle
  always_ff @(posedge clk_i) begin
    omb1_q  <= lion_pkg::fp_sub(lion_pkg::FP_ONE, b1_q);
    omb2_q  <= lion_pkg::fp_sub(lion_pkg::FP_ONE, b2_q);
    lrwd_q  <= lion_pkg::fp_mul(lr_q, wd_q);
    decay_q <= lion_pkg::fp_sub(lion_pkg::FP_ONE, lrwd_q);
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: input register
  lion_pkg::in_word_t s1_q;
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) s1_q <= in_word_i;
  end

  // stage 2: the four products
  logic [31:0] bm1_q, og1_q, bm2_q, og2_q, p2_q;
  logic        l2_q;
  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      bm1_q <= lion_pkg::fp_mul(b1_q, s1_q.momentum_in);
      og1_q <= lion_pkg::fp_mul(omb1_q, s1_q.grad_in);
      bm2_q <= lion_pkg::fp_mul(b2_q, s1_q.momentum_in);
      og2_q <= lion_pkg::fp_mul(omb2_q, s1_q.grad_in);
      p2_q  <= s1_q.param_in;
      l2_q  <= s1_q.last_element;
    end
  end

  // stage 3: interpolation and new momentum
  logic [31:0] interp_q, m3_q, p3_q;
  logic        l3_q;
  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      interp_q <= lion_pkg::fp_add(bm1_q, og1_q);
      m3_q     <= lion_pkg::fp_add(bm2_q, og2_q);
      p3_q     <= p2_q;
      l3_q     <= l2_q;
    end
  end

  // sign of interp: NaN and both zeros give 0
  logic [31:0] sgn;
  always_comb begin
    if (interp_q[30:0] == 31'd0 ||
        (interp_q[30:23] == 8'hFF && interp_q[22:0] != 23'd0)) begin
      sgn = lion_pkg::FP_ZERO;
    end else if (interp_q[31]) begin
      sgn = lion_pkg::FP_NEG_ONE;
    end else begin
      sgn = lion_pkg::FP_ONE;
    end
  end

  // stage 4: decayed parameter and step
  logic [31:0] pd_q, st_q, m4_q;
  logic        l4_q;
  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      pd_q <= lion_pkg::fp_mul(p3_q, decay_q);
      st_q <= lion_pkg::fp_mul(lr_q, sgn);
      m4_q <= m3_q;
      l4_q <= l3_q;
    end
  end

  // stage 5: output register
  lion_pkg::out_word_t s5_q;
  always_ff @(posedge clk_i) begin
    if (v4_q && rdy5) begin
      s5_q.param_out    <= lion_pkg::fp_sub(pd_q, st_q);
      s5_q.momentum_out <= m4_q;
      s5_q.last_out     <= l4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_word_o  = s5_q;

endmodule
